// ----- design/bsrc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the banker's safety and request check block.
// No dependencies; used by the top level, the port checker and the bench.
package bsrc_pkg;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_AVAIL   = 2'd1,
    OP_CHECK   = 2'd2,
    OP_REQUEST = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    STS_LOADED      = 3'd0,
    STS_SAFE        = 3'd1,
    STS_UNSAFE      = 3'd2,
    STS_GRANTED     = 3'd3,
    STS_ROLLED_BACK = 3'd4,
    STS_EXCEEDS     = 3'd5,
    STS_WAIT        = 3'd6,
    STS_BAD_ENTRY   = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_CHECK,
    S_FAIL,
    S_EMIT
  } state_t;

  // number of request fields carried by one input item
  localparam int REQ_FIELDS = 4;

  // configuration register selection (paddr bit 2)
  localparam int   CFG_ADDR_W    = 3;
  localparam logic CFG_SEL_PROCS = 1'b0;
  localparam logic CFG_SEL_RES   = 1'b1;

  localparam logic [3:0] PROCS_RESET = 4'd8;
  localparam logic [2:0] RES_RESET   = 3'd4;

  typedef struct packed {
    logic [1:0] operation;
    logic [2:0] process;
    logic [1:0] resource;
    logic [7:0] max_count;
    logic [7:0] alloc_count;
    logic [7:0] avail_count;
    logic [7:0] req_0;
    logic [7:0] req_1;
    logic [7:0] req_2;
    logic [7:0] req_3;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] seq_process;
    logic       seq_valid;
    logic       last;
  } out_item_t;

endpackage

// ----- design/bsrc_lane.sv -----
`timescale 1ns / 1ps
// One process lane: tests whether the process's remaining need fits the work vector.
// Standalone; instantiated once per process by the top level.
module bsrc_lane #(
  parameter int MAX_RESOURCES = 4,
  parameter int COUNT_BITS    = 8,
  parameter int WORK_W        = 12,
  parameter int NR_W          = 3
) (
  input  logic [MAX_RESOURCES-1:0][COUNT_BITS-1:0] need_row,
  input  logic [MAX_RESOURCES-1:0][WORK_W-1:0]     work,
  input  logic [NR_W-1:0]                          nr,
  input  logic                                     enable,
  output logic                                     fits
);

  always_comb begin
    fits = enable;
    for (int r = 0; r < MAX_RESOURCES; r++) begin
      if (NR_W'(r) < nr && WORK_W'(need_row[r]) > work[r]) begin
        fits = 1'b0;
      end
    end
  end

endmodule

// ----- design/bsrc_merge.sv -----
`timescale 1ns / 1ps
// Merge stage: picks the lowest fitting lane at or after the scan position.
// Standalone; fed by the lane fit flags of the top level.
module bsrc_merge #(
  parameter int MAX_PROCESSES = 8,
  parameter int POS_W         = 4,
  parameter int IDX_W         = 3
) (
  input  logic [MAX_PROCESSES-1:0] fits,
  input  logic [POS_W-1:0]         pos,
  output logic                     found,
  output logic [IDX_W-1:0]         pick
);

  // scan downward so the lowest qualifying lane wins
  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int p = MAX_PROCESSES - 1; p >= 0; p--) begin
      if (fits[p] && POS_W'(p) >= pos) begin
        found = 1'b1;
        pick  = IDX_W'(p);
      end
    end
  end

endmodule

// ----- design/bankers_safety_and_request_check.sv -----
`timescale 1ns / 1ps
// Banker's algorithm resource manager: tables, sequencer and output register.
// Depends on bsrc_pkg, bsrc_lane and bsrc_merge.
//
// One item is taken at a time. Load entry and set available write their result
// from the execute state once the output register is free; a request that is
// rejected or must wait likewise. A safety check (alone or after a tentative
// grant) retires one process at a time and starts a new scan pass when a pass
// with progress ends, through the single work-vector adder fed from the merge stage; all
// lanes test their need row against the work vector in parallel. A safe result
// then streams np transfers, one per cycle while out_stall is low; an unsafe
// result (and the rollback of a tentative grant) is one transfer. The next item
// is taken as soon as the last result sits in the output register.
module bankers_safety_and_request_check #(
  parameter int MAX_PROCESSES = 8,
  parameter int MAX_RESOURCES = 4,
  parameter int COUNT_BITS    = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bsrc_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bsrc_pkg::out_item_t            out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bsrc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int PIDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int RIDX_W = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int NPW    = $clog2(MAX_PROCESSES + 1);
  localparam int NRW    = $clog2(MAX_RESOURCES + 1);
  localparam int CW     = COUNT_BITS;
  localparam int WW     = COUNT_BITS + $clog2(MAX_PROCESSES + 1);

  // ---------------------------------------------------------------- config
  logic [3:0] cfg_procs_r;
  logic [2:0] cfg_res_r;
  logic       cfg_wr;
  logic [NPW-1:0] np;
  logic [NRW-1:0] nr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_procs_r <= bsrc_pkg::PROCS_RESET;
      cfg_res_r   <= bsrc_pkg::RES_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        bsrc_pkg::CFG_SEL_PROCS: cfg_procs_r <= pwdata[3:0];
        bsrc_pkg::CFG_SEL_RES:   cfg_res_r   <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      bsrc_pkg::CFG_SEL_PROCS: prdata = 32'(cfg_procs_r);
      bsrc_pkg::CFG_SEL_RES:   prdata = 32'(cfg_res_r);
      default:                 prdata = '0;
    endcase
  end

  // saturate the active counts into their legal ranges
  always_comb begin
    if (cfg_procs_r == '0) np = NPW'(1);
    else if (32'(cfg_procs_r) > 32'(MAX_PROCESSES)) np = NPW'(MAX_PROCESSES);
    else np = NPW'(cfg_procs_r);
    if (cfg_res_r == '0) nr = NRW'(1);
    else if (32'(cfg_res_r) > 32'(MAX_RESOURCES)) nr = NRW'(MAX_RESOURCES);
    else nr = NRW'(cfg_res_r);
  end

  // ---------------------------------------------------------------- state
  bsrc_pkg::state_t state_r, state_nxt;
  bsrc_pkg::in_item_t in_r;

  logic [MAX_RESOURCES-1:0][CW-1:0] alloc_r [MAX_PROCESSES];
  logic [MAX_RESOURCES-1:0][CW-1:0] need_r  [MAX_PROCESSES];
  logic [MAX_RESOURCES-1:0][CW-1:0] avail_r;
  logic [MAX_RESOURCES-1:0][WW-1:0] work_r;
  logic [MAX_PROCESSES-1:0]         fin_r;
  logic [PIDX_W-1:0]                order_r [MAX_PROCESSES];
  logic [NPW-1:0]                   done_r;
  logic [NPW-1:0]                   pos_r;
  logic                             prog_r;
  logic [PIDX_W-1:0]                k_r;
  logic                             out_valid_r;
  bsrc_pkg::out_item_t              out_data_r;

  // ---------------------------------------------------------------- decode
  bsrc_pkg::op_t op;
  logic [CW-1:0] mx, al, av;
  logic          proc_oor, res_oor, bad_req, exceeds, must_wait;
  logic [PIDX_W-1:0] pi;
  logic [RIDX_W-1:0] ri;
  logic [bsrc_pkg::REQ_FIELDS-1:0][7:0] req_fields;
  logic [MAX_RESOURCES-1:0][CW-1:0] req;
  logic [MAX_RESOURCES-1:0][CW-1:0] avail_adj;

  assign op       = bsrc_pkg::op_t'(in_r.operation);
  assign mx       = CW'(in_r.max_count);
  assign al       = CW'(in_r.alloc_count);
  assign av       = CW'(in_r.avail_count);
  assign proc_oor = 32'(in_r.process) >= 32'(MAX_PROCESSES);
  assign res_oor  = 32'(in_r.resource) >= 32'(MAX_RESOURCES);
  assign bad_req  = 32'(in_r.process) >= 32'(np);
  assign pi       = PIDX_W'(in_r.process);
  assign ri       = RIDX_W'(in_r.resource);
  assign req_fields = {in_r.req_3, in_r.req_2, in_r.req_1, in_r.req_0};

  // resource types beyond the request fields are asked for with zero units
  for (genvar r = 0; r < MAX_RESOURCES; r++) begin : g_req
    if (r < bsrc_pkg::REQ_FIELDS) begin : g_field
      assign req[r] = CW'(req_fields[r]);
    end else begin : g_zero
      assign req[r] = '0;
    end
  end

  always_comb begin
    exceeds   = 1'b0;
    must_wait = 1'b0;
    for (int r = 0; r < MAX_RESOURCES; r++) begin
      if (NRW'(r) < nr) begin
        if (req[r] > need_r[pi][r]) exceeds = 1'b1;
        if (req[r] > avail_r[r]) must_wait = 1'b1;
      end
    end
  end

  // available vector as it stands after a tentative grant
  always_comb begin
    for (int r = 0; r < MAX_RESOURCES; r++) begin
      avail_adj[r] = (op == bsrc_pkg::OP_REQUEST) ? avail_r[r] - req[r] : avail_r[r];
    end
  end

  logic              exec_check;
  bsrc_pkg::status_t exec_sts;

  always_comb begin
    exec_check = 1'b0;
    exec_sts   = bsrc_pkg::STS_LOADED;
    unique case (op)
      bsrc_pkg::OP_LOAD: begin
        if (proc_oor || res_oor || al > mx) exec_sts = bsrc_pkg::STS_BAD_ENTRY;
      end
      bsrc_pkg::OP_AVAIL: begin
        if (res_oor) exec_sts = bsrc_pkg::STS_BAD_ENTRY;
      end
      bsrc_pkg::OP_CHECK: begin
        exec_check = 1'b1;
      end
      bsrc_pkg::OP_REQUEST: begin
        if (bad_req) exec_sts = bsrc_pkg::STS_BAD_ENTRY;
        else if (exceeds) exec_sts = bsrc_pkg::STS_EXCEEDS;
        else if (must_wait) exec_sts = bsrc_pkg::STS_WAIT;
        else exec_check = 1'b1;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- lanes
  logic [MAX_PROCESSES-1:0] lane_en, fits;
  logic                     found;
  logic [PIDX_W-1:0]        pick;

  for (genvar p = 0; p < MAX_PROCESSES; p++) begin : g_lane
    assign lane_en[p] = (NPW'(p) < np) && !fin_r[p];
    bsrc_lane #(
      .MAX_RESOURCES (MAX_RESOURCES),
      .COUNT_BITS    (COUNT_BITS),
      .WORK_W        (WW),
      .NR_W          (NRW)
    ) u_lane (
      .need_row (need_r[p]),
      .work     (work_r),
      .nr       (nr),
      .enable   (lane_en[p]),
      .fits     (fits[p])
    );
  end

  bsrc_merge #(
    .MAX_PROCESSES (MAX_PROCESSES),
    .POS_W         (NPW),
    .IDX_W         (PIDX_W)
  ) u_merge (
    .fits  (fits),
    .pos   (pos_r),
    .found (found),
    .pick  (pick)
  );

  logic [NPW-1:0]                   done_inc;
  logic [MAX_RESOURCES-1:0][WW-1:0] work_sum;
  logic                             check_done;

  assign done_inc   = done_r + NPW'(1);
  assign check_done = found && (done_inc == np);

  always_comb begin
    for (int r = 0; r < MAX_RESOURCES; r++) begin
      work_sum[r] = work_r[r] + WW'(alloc_r[pick][r]);
    end
  end

  // ---------------------------------------------------------------- control
  logic out_free, in_acc, emit_last;
  logic res_load, tbl_load, avail_set, grant_apply, rollback, check_init;
  bsrc_pkg::out_item_t res_item;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign emit_last = (32'(k_r) + 32'd1) == 32'(np);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bsrc_pkg::S_IDLE:  if (in_valid) state_nxt = bsrc_pkg::S_EXEC;
      bsrc_pkg::S_EXEC: begin
        if (exec_check) state_nxt = bsrc_pkg::S_CHECK;
        else if (out_free) state_nxt = bsrc_pkg::S_IDLE;
      end
      bsrc_pkg::S_CHECK: begin
        if (check_done) state_nxt = bsrc_pkg::S_EMIT;
        else if (!found && !prog_r) state_nxt = bsrc_pkg::S_FAIL;
      end
      bsrc_pkg::S_FAIL:  if (out_free) state_nxt = bsrc_pkg::S_IDLE;
      bsrc_pkg::S_EMIT:  if (out_free && emit_last) state_nxt = bsrc_pkg::S_IDLE;
      default:           state_nxt = bsrc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = state_r != bsrc_pkg::S_IDLE;
    res_load    = 1'b0;
    res_item    = '0;
    tbl_load    = 1'b0;
    avail_set   = 1'b0;
    grant_apply = 1'b0;
    rollback    = 1'b0;
    check_init  = 1'b0;
    unique case (state_r)
      bsrc_pkg::S_EXEC: begin
        if (exec_check) begin
          check_init  = 1'b1;
          grant_apply = op == bsrc_pkg::OP_REQUEST;
        end else if (out_free) begin
          res_load        = 1'b1;
          res_item.status = exec_sts;
          res_item.last   = 1'b1;
          tbl_load  = (op == bsrc_pkg::OP_LOAD) && (exec_sts == bsrc_pkg::STS_LOADED);
          avail_set = (op == bsrc_pkg::OP_AVAIL) && (exec_sts == bsrc_pkg::STS_LOADED);
        end
      end
      bsrc_pkg::S_FAIL: begin
        if (out_free) begin
          res_load        = 1'b1;
          res_item.last   = 1'b1;
          rollback        = op == bsrc_pkg::OP_REQUEST;
          res_item.status = (op == bsrc_pkg::OP_REQUEST) ? bsrc_pkg::STS_ROLLED_BACK
                                                         : bsrc_pkg::STS_UNSAFE;
        end
      end
      bsrc_pkg::S_EMIT: begin
        if (out_free) begin
          res_load             = 1'b1;
          res_item.status      = (op == bsrc_pkg::OP_REQUEST) ? bsrc_pkg::STS_GRANTED
                                                              : bsrc_pkg::STS_SAFE;
          res_item.seq_process = 3'(order_r[k_r]);
          res_item.seq_valid   = 1'b1;
          res_item.last        = emit_last;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= bsrc_pkg::S_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_acc) in_r <= in_data;
  end

  // ---------------------------------------------------------------- tables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alloc_r <= '{default: '0};
      need_r  <= '{default: '0};
      avail_r <= '0;
    end else begin
      if (tbl_load) begin
        alloc_r[pi][ri] <= al;
        need_r[pi][ri]  <= mx - al;
      end
      if (avail_set) avail_r[ri] <= av;
      for (int r = 0; r < MAX_RESOURCES; r++) begin
        if (NRW'(r) < nr) begin
          if (grant_apply) begin
            avail_r[r]    <= avail_r[r] - req[r];
            alloc_r[pi][r] <= alloc_r[pi][r] + req[r];
            need_r[pi][r]  <= need_r[pi][r] - req[r];
          end else if (rollback) begin
            avail_r[r]    <= avail_r[r] + req[r];
            alloc_r[pi][r] <= alloc_r[pi][r] - req[r];
            need_r[pi][r]  <= need_r[pi][r] + req[r];
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- check
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_r  <= '0;
      done_r <= '0;
      pos_r  <= '0;
      prog_r <= 1'b0;
    end else if (check_init) begin
      fin_r  <= '0;
      done_r <= '0;
      pos_r  <= '0;
      prog_r <= 1'b0;
    end else if (state_r == bsrc_pkg::S_CHECK) begin
      if (found) begin
        fin_r[pick] <= 1'b1;
        done_r      <= done_inc;
        pos_r       <= NPW'(pick) + NPW'(1);
        prog_r      <= 1'b1;
      end else begin
        // end of a pass: rescan from the first process
        pos_r  <= '0;
        prog_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (check_init) begin
      for (int r = 0; r < MAX_RESOURCES; r++) work_r[r] <= WW'(avail_adj[r]);
    end else if (state_r == bsrc_pkg::S_CHECK && found) begin
      work_r <= work_sum;
      order_r[done_r[PIDX_W-1:0]] <= pick;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) k_r <= '0;
    else if (check_done) k_r <= '0;
    else if (state_r == bsrc_pkg::S_EMIT && res_load) k_r <= k_r + PIDX_W'(1);
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (res_load) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (res_load) out_data_r <= res_item;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- design/bsrc_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the banker's check block, bound to the top level.
// Depends on bsrc_pkg and bankers_safety_and_request_check.
module bsrc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input bsrc_pkg::out_item_t out_data
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one item in flight: busy right after an input transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous item still in work");

  // results without a sequence element are single results
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.seq_valid |-> out_data.last && out_data.seq_process == 3'd0)
    else $error("non-sequence result not marked last or carries a process");

  // sequence elements only come with safe or granted
  a_seq_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.seq_valid |->
      out_data.status == bsrc_pkg::STS_SAFE || out_data.status == bsrc_pkg::STS_GRANTED)
    else $error("sequence element with wrong status");

endmodule

bind bankers_safety_and_request_check bsrc_checker u_bsrc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for bankers_safety_and_request_check: directed and random transfers
// across several process/resource settings. Needs bsrc_pkg and the RTL.

class bank_scoreboard;
  logic [7:0] alloc_tbl [8][4];
  logic [7:0] need_tbl [8][4];
  logic [7:0] free_units [4];
  logic [3:0] procs_reg;
  logic [2:0] res_reg;
  logic [2:0] safe_seq [8];
  bsrc_pkg::out_item_t pending [$];
  int errors;
  int results;
  int inputs;
  int status_hits [8];

  function new();
    procs_reg = bsrc_pkg::PROCS_RESET;
    res_reg = bsrc_pkg::RES_RESET;
    foreach (alloc_tbl[p, r]) begin
      alloc_tbl[p][r] = '0;
      need_tbl[p][r] = '0;
    end
    foreach (free_units[r]) free_units[r] = '0;
    foreach (status_hits[s]) status_hits[s] = 0;
    errors = 0;
    results = 0;
    inputs = 0;
  endfunction

  // register values outside the legal range saturate
  function int live_procs();
    if (procs_reg == 0) return 1;
    if (procs_reg > 8) return 8;
    return procs_reg;
  endfunction

  function int live_res();
    if (res_reg == 0) return 1;
    if (res_reg > 4) return 4;
    return res_reg;
  endfunction

  function void write_reg(logic sel, logic [31:0] value);
    if (sel == bsrc_pkg::CFG_SEL_PROCS) procs_reg = value[3:0];
    else res_reg = value[2:0];
  endfunction

  // scan passes until every process retires or a pass makes no progress
  function bit find_safe_order(int np, int nr);
    int work [4];
    bit [7:0] retired;
    int done, p, r;
    bit moved, fits;
    for (r = 0; r < nr; r++) work[r] = free_units[r];
    retired = '0;
    done = 0;
    while (done < np) begin
      moved = 1'b0;
      for (p = 0; p < np; p++) begin
        if (retired[p]) continue;
        fits = 1'b1;
        for (r = 0; r < nr; r++)
          if (need_tbl[p][r] > work[r]) fits = 1'b0;
        if (!fits) continue;
        for (r = 0; r < nr; r++) work[r] += alloc_tbl[p][r];
        retired[p] = 1'b1;
        safe_seq[done] = 3'(p);
        done++;
        moved = 1'b1;
      end
      if (!moved) return 1'b0;
    end
    return 1'b1;
  endfunction

  function void expect_one(bsrc_pkg::status_t s);
    bsrc_pkg::out_item_t e;
    e = '0;
    e.status = s;
    e.last = 1'b1;
    pending.push_back(e);
  endfunction

  function void expect_seq(bsrc_pkg::status_t s, int np);
    bsrc_pkg::out_item_t e;
    int k;
    for (k = 0; k < np; k++) begin
      e = '0;
      e.status = s;
      e.seq_process = safe_seq[k];
      e.seq_valid = 1'b1;
      e.last = (k == np - 1);
      pending.push_back(e);
    end
  endfunction

  function void note_input(bsrc_pkg::in_item_t it);
    int np, nr, p, r;
    logic [7:0] want [4];
    np = live_procs();
    nr = live_res();
    p = it.process;
    want[0] = it.req_0;
    want[1] = it.req_1;
    want[2] = it.req_2;
    want[3] = it.req_3;
    inputs++;
    case (bsrc_pkg::op_t'(it.operation))
      bsrc_pkg::OP_LOAD: begin
        if (it.alloc_count > it.max_count) begin
          expect_one(bsrc_pkg::STS_BAD_ENTRY);
        end else begin
          alloc_tbl[p][it.resource] = it.alloc_count;
          need_tbl[p][it.resource] = it.max_count - it.alloc_count;
          expect_one(bsrc_pkg::STS_LOADED);
        end
      end
      bsrc_pkg::OP_AVAIL: begin
        free_units[it.resource] = it.avail_count;
        expect_one(bsrc_pkg::STS_LOADED);
      end
      bsrc_pkg::OP_CHECK: begin
        if (find_safe_order(np, nr)) expect_seq(bsrc_pkg::STS_SAFE, np);
        else expect_one(bsrc_pkg::STS_UNSAFE);
      end
      default: begin
        if (p >= np) begin
          expect_one(bsrc_pkg::STS_BAD_ENTRY);
          return;
        end
        for (r = 0; r < nr; r++)
          if (want[r] > need_tbl[p][r]) begin
            expect_one(bsrc_pkg::STS_EXCEEDS);
            return;
          end
        for (r = 0; r < nr; r++)
          if (want[r] > free_units[r]) begin
            expect_one(bsrc_pkg::STS_WAIT);
            return;
          end
        for (r = 0; r < nr; r++) begin
          free_units[r] -= want[r];
          alloc_tbl[p][r] += want[r];
          need_tbl[p][r] -= want[r];
        end
        if (find_safe_order(np, nr)) begin
          expect_seq(bsrc_pkg::STS_GRANTED, np);
        end else begin
          // tentative grant undone
          for (r = 0; r < nr; r++) begin
            free_units[r] += want[r];
            alloc_tbl[p][r] -= want[r];
            need_tbl[p][r] += want[r];
          end
          expect_one(bsrc_pkg::STS_ROLLED_BACK);
        end
      end
    endcase
  endfunction

  function void field_check(string name, logic [2:0] exp_v, logic [2:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
      errors++;
    end
  endfunction

  function void check_result(bsrc_pkg::out_item_t got);
    bsrc_pkg::out_item_t e;
    results++;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result, expected none, got status %0d seq %0d/%0b last %0b",
               $time, got.status, got.seq_process, got.seq_valid, got.last);
      errors++;
      return;
    end
    e = pending.pop_front();
    field_check("status", e.status, got.status);
    field_check("seq_process", e.seq_process, got.seq_process);
    field_check("seq_valid", e.seq_valid, got.seq_valid);
    field_check("last", e.last, got.last);
    if (e.last) status_hits[e.status]++;
  endfunction
endclass

module testbench;
  localparam int PERIOD = 20;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 30;
  localparam int PHASES = 7;
  localparam int OPS_PER_PHASE = 4;

  typedef enum {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  bsrc_pkg::in_item_t  in_data;
  logic        out_valid;
  logic        out_stall;
  bsrc_pkg::out_item_t out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [bsrc_pkg::CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // out-of-range settings included on purpose; they saturate
  logic [3:0] procs_plan [PHASES] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd5, 4'd2};
  logic [2:0] res_plan [PHASES] = '{3'd4, 3'd1, 3'd0, 3'd7, 3'd2, 3'd3, 3'd4};

  bank_scoreboard sb = new();
  int cycle_count = 0;
  int burst_left = 0;
  int cfg_writes = 0;
  bit hold_req = 1'b0;

  bankers_safety_and_request_check u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #(PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("bankers_safety_and_request_check verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (in_valid && !in_stall) sb.note_input(in_data);
    end
  end

  // receiver: stall pattern in segments, plus one long hold-off on request
  initial begin : receiver
    int seg_left;
    int hold_left;
    rx_mode_t mode;
    out_stall = 1'b0;
    seg_left = 0;
    hold_left = 0;
    mode = RX_FLOW;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          seg_left = $urandom_range(8, 60);
        end
        seg_left--;
        case (mode)
          RX_FLOW:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY: out_stall <= ($urandom_range(0, 9) < 6);
          default:  out_stall <= ~out_stall;
        endcase
      end
    end
  end

  function automatic bsrc_pkg::in_item_t mk(bsrc_pkg::op_t op, int p = 0, int r = 0,
                                            int mx = 0, int al = 0, int av = 0,
                                            int q0 = 0, int q1 = 0, int q2 = 0,
                                            int q3 = 0);
    bsrc_pkg::in_item_t it;
    it.operation = op;
    it.process = 3'(p);
    it.resource = 2'(r);
    it.max_count = 8'(mx);
    it.alloc_count = 8'(al);
    it.avail_count = 8'(av);
    it.req_0 = 8'(q0);
    it.req_1 = 8'(q1);
    it.req_2 = 8'(q2);
    it.req_3 = 8'(q3);
    return it;
  endfunction

  // mostly requests sized to fit need and free units, so grants and safe
  // sequences dominate; some noise requests, loads beyond claim and wide values
  function automatic bsrc_pkg::in_item_t random_item();
    bsrc_pkg::in_item_t it;
    logic [63:0] noise;
    logic [7:0] q [4];
    int np, nr, r, pick, cap;
    noise = {$urandom, $urandom};
    it = noise[$bits(bsrc_pkg::in_item_t)-1:0];
    np = sb.live_procs();
    nr = sb.live_res();
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      it.operation = bsrc_pkg::OP_REQUEST;
      it.process = 3'($urandom_range(0, np - 1));
      q[0] = it.req_0;
      q[1] = it.req_1;
      q[2] = it.req_2;
      q[3] = it.req_3;
      for (r = 0; r < nr; r++) begin
        cap = sb.need_tbl[it.process][r];
        if ($urandom_range(0, 4) != 0 && sb.free_units[r] < cap) cap = sb.free_units[r];
        q[r] = 8'($urandom_range(0, cap));
      end
      it.req_0 = q[0];
      it.req_1 = q[1];
      it.req_2 = q[2];
      it.req_3 = q[3];
    end else if (pick < 52) begin
      it.operation = bsrc_pkg::OP_REQUEST;
    end else if (pick < 67) begin
      it.operation = bsrc_pkg::OP_CHECK;
    end else if (pick < 85) begin
      it.operation = bsrc_pkg::OP_LOAD;
      if ($urandom_range(0, 4) != 0) begin
        it.process = 3'($urandom_range(0, np - 1));
        it.resource = 2'($urandom_range(0, nr - 1));
      end
      it.max_count = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 40))
                                                  : 8'($urandom_range(0, 255));
      it.alloc_count = ($urandom_range(0, 9) != 0) ? 8'($urandom_range(0, it.max_count))
                                                   : 8'($urandom_range(it.max_count, 255));
    end else begin
      it.operation = bsrc_pkg::OP_AVAIL;
      if ($urandom_range(0, 4) != 0) it.resource = 2'($urandom_range(0, nr - 1));
      it.avail_count = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(30, 120))
                                                   : 8'($urandom_range(0, 255));
    end
    return it;
  endfunction

  // bursts of transfers with random gaps between them
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 10);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic drive_item(input bsrc_pkg::in_item_t it);
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send(input bsrc_pkg::in_item_t it);
    pace();
    @(negedge clk);
    drive_item(it);
  endtask

  // item built after the negedge so the scoreboard has seen the previous transfer
  task automatic send_random();
    pace();
    @(negedge clk);
    drive_item(random_item());
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic settle();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic sel, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(sel, value);
    cfg_writes++;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin : stimulus
    int ph, k, p, r, mx;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset settings: 8 processes, 4 resource types
    send(mk(bsrc_pkg::OP_CHECK));                          // empty tables are trivially safe
    send(mk(bsrc_pkg::OP_LOAD, 7, 3, 255, 255));
    send(mk(bsrc_pkg::OP_LOAD, 0, 0, 0, 255));             // allocation above claim
    send(mk(bsrc_pkg::OP_LOAD, 0, 0, 255, 0));
    send(mk(bsrc_pkg::OP_AVAIL, 0, 0, 0, 0, 255));
    send(mk(bsrc_pkg::OP_AVAIL, 0, 3, 0, 0, 0));
    send(mk(bsrc_pkg::OP_REQUEST, 0, 0, 0, 0, 0, 255));    // full claim, granted
    send(mk(bsrc_pkg::OP_REQUEST, 0, 0, 0, 0, 0, 1));      // beyond need
    send(mk(bsrc_pkg::OP_LOAD, 1, 1, 10, 0));
    send(mk(bsrc_pkg::OP_AVAIL, 0, 1, 0, 0, 4));
    send(mk(bsrc_pkg::OP_REQUEST, 1, 0, 0, 0, 0, 0, 5));   // within need, beyond free units
    send(mk(bsrc_pkg::OP_LOAD, 1, 1, 0, 0));
    send(mk(bsrc_pkg::OP_LOAD, 2, 2, 3, 2));
    send(mk(bsrc_pkg::OP_LOAD, 3, 2, 5, 2));
    send(mk(bsrc_pkg::OP_AVAIL, 0, 2, 0, 0, 1));
    send(mk(bsrc_pkg::OP_CHECK));
    send(mk(bsrc_pkg::OP_REQUEST, 3, 0, 0, 0, 0, 0, 0, 1)); // leaves processes 2 and 3 unable to finish
    send(mk(bsrc_pkg::OP_REQUEST, 2, 0, 0, 0, 0, 0, 0, 1));
    send(mk(bsrc_pkg::OP_REQUEST, 5, 0, 0, 0, 0, 255, 255, 255, 255));
    send(mk(bsrc_pkg::OP_LOAD, 4, 1, 255, 0));
    send(mk(bsrc_pkg::OP_CHECK));                          // unsafe
    send(mk(bsrc_pkg::OP_LOAD, 4, 1, 0, 0));
    drop_valid();
    settle();
    cfg_write(bsrc_pkg::CFG_SEL_PROCS, 32'd3);
    send(mk(bsrc_pkg::OP_REQUEST, 5));                     // process outside the active set
    send(mk(bsrc_pkg::OP_REQUEST, 2));
    drop_valid();
    settle();

    for (ph = 0; ph < PHASES; ph++) begin
      cfg_write(bsrc_pkg::CFG_SEL_PROCS, 32'(procs_plan[ph]));
      cfg_write(bsrc_pkg::CFG_SEL_RES, 32'(res_plan[ph]));
      if (ph == 0) begin
        for (p = 0; p < 8; p++)
          for (r = 0; r < 4; r++) begin
            mx = $urandom_range(0, 40);
            send(mk(bsrc_pkg::OP_LOAD, p, r, mx, $urandom_range(0, mx)));
          end
        hold_req = 1'b1;                         // receiver backs up while we keep sending
      end
      for (r = 0; r < sb.live_res(); r++)
        send(mk(bsrc_pkg::OP_AVAIL, 0, r, 0, 0, $urandom_range(30, 120)));
      for (k = 0; k < OPS_PER_PHASE; k++) send_random();
      drop_valid();
      settle();
    end

    $display("covered %0d transfers in, %0d results, %0d register writes",
             sb.inputs, sb.results, cfg_writes);
    $display("outcomes: safe %0d unsafe %0d granted %0d rolled back %0d",
             sb.status_hits[bsrc_pkg::STS_SAFE], sb.status_hits[bsrc_pkg::STS_UNSAFE],
             sb.status_hits[bsrc_pkg::STS_GRANTED],
             sb.status_hits[bsrc_pkg::STS_ROLLED_BACK]);
    $display("          wait %0d exceeds %0d bad %0d",
             sb.status_hits[bsrc_pkg::STS_WAIT], sb.status_hits[bsrc_pkg::STS_EXCEEDS],
             sb.status_hits[bsrc_pkg::STS_BAD_ENTRY]);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("bankers_safety_and_request_check verification clean");
    end else begin
      $display("bankers_safety_and_request_check verification failed");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
design/bsrc_pkg.sv
design/bsrc_lane.sv
design/bsrc_merge.sv
design/bankers_safety_and_request_check.sv
design/bsrc_checker.sv
tb/testbench.sv
